FILE: src/dcc_half_bit_decoder_macros.svh
// Assertion macros shared by the half-bit decoder modules.
// Included by every module that carries concurrent assertions.
`ifndef DCC_HALF_BIT_DECODER_MACROS_SVH
`define DCC_HALF_BIT_DECODER_MACROS_SVH

// Implication checked in the same cycle, ignored while reset is held
`define DCC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("decoder assertion failed");

// Implication checked in the next cycle, ignored while reset is held
`define DCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("decoder assertion failed");

`endif

FILE: src/dcc_hb_pkg.sv
// Shared types and constants for the DCC half-bit decoder.
// No dependencies; imported by every module of the block.
package dcc_hb_pkg;

    localparam int WORD_BITS    = 32;
    localparam int BITS_W       = 7;
    localparam int STAMP_W      = 16;
    localparam int SETTLE_EDGES = 5;
    localparam int SETTLE_MAX   = 7;
    localparam int ERR_W        = 8;
    localparam int OQ_DEPTH     = 4;
    localparam int OQ_PTR_W     = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W     = $clog2(OQ_DEPTH + 1);
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_MIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_MAX  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_MIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_MAX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ERR_LIM  = 3'd4;

    typedef enum logic [2:0] {
        EV_WORD  = 3'd0,
        EV_SHORT = 3'd1,
        EV_MID   = 3'd2,
        EV_LONG  = 3'd3,
        EV_OTHER = 3'd4,
        EV_LIMIT = 3'd5
    } t_event_kind;

    typedef struct packed {
        logic [STAMP_W-1:0] one_min;
        logic [STAMP_W-1:0] one_max;
        logic [STAMP_W-1:0] zero_min;
        logic [STAMP_W-1:0] zero_max;
        logic [ERR_W-1:0]   err_limit;
    } t_cfg;

    // classification of one period
    typedef struct packed {
        logic        is_one;
        logic        valid;
        t_event_kind err_kind;
    } t_class;

    typedef struct packed {
        t_event_kind          kind;
        logic [WORD_BITS-1:0] word;
        logic                 last;
    } t_result;

    // up to two results written into the output queue in one cycle
    typedef struct packed {
        logic [1:0]        n;
        t_result [1:0]     slot;
    } t_push;

endpackage

FILE: src/dcc_half_bit_decoder.sv
// Channel   | Signals                                  | Contents
// s_axis    | tvalid, tready, tdata[15:0]              | edge timestamp in
// m_axis    | tvalid, tready, tdata, tuser, tlast      | word / error events out
// cfg       | valid, ready, index[2:0], data[15:0]     | window and limit registers
//
// One edge is taken per cycle unless the result queue lacks space; each edge is held in the
// input register, and its results are written into the result queue before they are offered.
// An edge causes zero, one or two results; a pair leaves the queue one result at a time.
// Input stalls while an edge is held and the four-entry result queue holds more than two results.
// Synchronous active-low reset returns to startup with default windows; no clearing pass.
// Top level of the DCC half-bit decoder: configuration registers, core and result queue.
// Depends on dcc_hb_pkg, dcc_hb_core and dcc_hb_outq.
module dcc_half_bit_decoder
    import dcc_hb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [STAMP_W-1:0]    i_s_axis_tdata,   // [15:0] edge_stamp
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [WORD_BITS-1:0]  o_m_axis_tdata,   // [31:0] data_word
    output logic [2:0]            o_m_axis_tuser,   // [2:0] event_kind
    output logic                  o_m_axis_tlast,   // last_of_run
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    r_cfg;
    t_push   push;
    logic    space_ok;
    t_result result;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.one_min   <= 16'd832;
            r_cfg.one_max   <= 16'd1024;
            r_cfg.zero_min  <= 16'd1440;
            r_cfg.zero_max  <= 16'd16000;
            r_cfg.err_limit <= 8'd10;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ONE_MIN:  r_cfg.one_min   <= i_cfg_data;
                CFG_ONE_MAX:  r_cfg.one_max   <= i_cfg_data;
                CFG_ZERO_MIN: r_cfg.zero_min  <= i_cfg_data;
                CFG_ZERO_MAX: r_cfg.zero_max  <= i_cfg_data;
                CFG_ERR_LIM:  r_cfg.err_limit <= i_cfg_data[ERR_W-1:0];
                default: ;
            endcase
        end
    end

    dcc_hb_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_stamp    (i_s_axis_tdata),
        .i_cfg      (r_cfg),
        .i_space_ok (space_ok),
        .o_push     (push)
    );

    dcc_hb_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_space_ok (space_ok),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_result   (result)
    );

    assign o_m_axis_tdata = result.word;
    assign o_m_axis_tuser = result.kind;
    assign o_m_axis_tlast = result.last;

endmodule

FILE: src/dcc_hb_classify.sv
// Period measurement and half-bit classification against the windows.
// Depends on dcc_hb_pkg.
module dcc_hb_classify
    import dcc_hb_pkg::*;
(
    input  logic [STAMP_W-1:0] i_stamp,
    input  logic [STAMP_W-1:0] i_prev_stamp,
    input  t_cfg               i_cfg,
    output t_class             o_class
);

    logic [STAMP_W-1:0] period;
    logic               is_one;
    logic               is_zero;
    t_event_kind        kind;

    // period wraps with the free-running timer
    assign period  = i_stamp - i_prev_stamp;
    assign is_one  = (period >= i_cfg.one_min) && (period <= i_cfg.one_max);
    assign is_zero = (period >= i_cfg.zero_min) && (period <= i_cfg.zero_max);

    // error kind: later tests take priority
    always_comb begin
        kind = EV_OTHER;
        if (period < i_cfg.one_min) begin
            kind = EV_SHORT;
        end
        if ((period > i_cfg.one_max) && (period < i_cfg.zero_min)) begin
            kind = EV_MID;
        end
        if (period > i_cfg.zero_max) begin
            kind = EV_LONG;
        end
    end

    assign o_class.is_one   = is_one;
    assign o_class.valid    = is_one || is_zero;
    assign o_class.err_kind = kind;

endmodule

FILE: src/dcc_hb_core.sv
// Input register, phase state machine and bit assembly for the decoder.
// Depends on dcc_hb_pkg, dcc_hb_classify and the assertion macro header.
`include "dcc_half_bit_decoder_macros.svh"
module dcc_hb_core
    import dcc_hb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [STAMP_W-1:0] i_stamp,
    input  t_cfg               i_cfg,
    input  logic               i_space_ok,
    output t_push              o_push
);

    typedef enum logic [1:0] {
        PH_STARTUP = 2'd0,
        PH_SEEK    = 2'd1,
        PH_NORMAL  = 2'd2
    } t_phase;

    logic               r_in_valid;
    logic [STAMP_W-1:0] r_stamp;
    t_phase             r_phase,      n_phase;
    logic [2:0]         r_settle,     n_settle;
    logic               r_prev_hb,    n_prev_hb;
    logic               r_pending,    n_pending;
    logic [ERR_W-1:0]   r_errs,       n_errs;
    logic [STAMP_W-1:0] r_prev_stamp;
    logic [BITS_W-1:0]  r_bits_held,  n_bits_held;
    logic [WORD_BITS-1:0] r_word,     n_word;

    t_class               cls;
    t_push                push;
    logic                 advance;
    logic [ERR_W-1:0]     errs_inc;
    logic [2:0]           settle_inc;
    logic [BITS_W-1:0]    bits_inc;
    logic [WORD_BITS-1:0] shifted;

    dcc_hb_classify u_classify (
        .i_stamp      (r_stamp),
        .i_prev_stamp (r_prev_stamp),
        .i_cfg        (i_cfg),
        .o_class      (cls)
    );

    // the held item moves on once the queue can take two results
    assign advance = r_in_valid && i_space_ok;
    assign o_ready = !r_in_valid || i_space_ok;

    assign errs_inc   = (r_errs != {ERR_W{1'b1}}) ? r_errs + ERR_W'(1) : r_errs;
    assign settle_inc = (r_settle != 3'(SETTLE_MAX)) ? r_settle + 3'd1 : r_settle;
    assign bits_inc   = r_bits_held + BITS_W'(1);
    assign shifted    = {r_word[WORD_BITS-2:0], cls.is_one};

    // next state and results for the held edge
    always_comb begin
        n_phase     = r_phase;
        n_settle    = r_settle;
        n_prev_hb   = r_prev_hb;
        n_pending   = r_pending;
        n_errs      = r_errs;
        n_bits_held = r_bits_held;
        n_word      = r_word;
        push        = '0;
        case (r_phase)
            PH_SEEK: begin
                if (cls.valid) begin
                    if (cls.is_one != r_prev_hb) begin
                        n_pending = 1'b1;
                        n_phase   = PH_NORMAL;
                    end
                    n_prev_hb = cls.is_one;
                end else begin
                    n_phase = PH_STARTUP;
                end
            end
            PH_NORMAL: begin
                if (cls.valid) begin
                    if ((cls.is_one == r_prev_hb) && r_pending) begin
                        // second matching half completes a bit
                        if (bits_inc >= BITS_W'(WORD_BITS)) begin
                            push.n            = 2'd1;
                            push.slot[0].kind = EV_WORD;
                            push.slot[0].word = shifted;
                            n_bits_held       = '0;
                            n_word            = '0;
                        end else begin
                            n_bits_held = bits_inc;
                            n_word      = shifted;
                        end
                        n_pending = 1'b0;
                        n_errs    = '0;
                    end else begin
                        n_pending = 1'b1;
                    end
                    n_prev_hb = cls.is_one;
                end else begin
                    push.n            = 2'd1;
                    push.slot[0].kind = cls.err_kind;
                    n_errs            = errs_inc;
                    if (errs_inc > i_cfg.err_limit) begin
                        n_phase           = PH_STARTUP;
                        push.n            = 2'd2;
                        push.slot[1].kind = EV_LIMIT;
                    end
                end
            end
            default: begin
                // startup, also the unused phase code
                n_settle = settle_inc;
                if (cls.valid && (settle_inc > 3'(SETTLE_EDGES))) begin
                    n_settle  = '0;
                    n_pending = 1'b0;
                    n_errs    = '0;
                    n_prev_hb = cls.is_one;
                    n_phase   = PH_SEEK;
                end
            end
        endcase
        // mark the final result of this edge
        if (push.n == 2'd1) begin
            push.slot[0].last = 1'b1;
        end
        if (push.n == 2'd2) begin
            push.slot[1].last = 1'b1;
        end
        if (!advance) begin
            push.n = 2'd0;
        end
    end

    assign o_push = push;

    // input register and decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_phase      <= PH_STARTUP;
            r_settle     <= '0;
            r_prev_hb    <= 1'b0;
            r_pending    <= 1'b0;
            r_errs       <= '0;
            r_prev_stamp <= '0;
            r_bits_held  <= '0;
            r_word       <= '0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_phase      <= n_phase;
                r_settle     <= n_settle;
                r_prev_hb    <= n_prev_hb;
                r_pending    <= n_pending;
                r_errs       <= n_errs;
                r_prev_stamp <= r_stamp;
                r_bits_held  <= n_bits_held;
                r_word       <= n_word;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_stamp <= i_stamp;
        end
    end

    `DCC_ASSERT_NOW(a_bits_below_word, i_clk, i_rst_n, 1'b1, r_bits_held < BITS_W'(WORD_BITS))
    `DCC_ASSERT_NOW(a_pair_is_limit, i_clk, i_rst_n, o_push.n == 2'd2, o_push.slot[1].kind == EV_LIMIT)
    `DCC_ASSERT_NEXT(a_limit_restarts, i_clk, i_rst_n, o_push.n == 2'd2, r_phase == PH_STARTUP)

endmodule

FILE: src/dcc_hb_outq.sv
// Four-entry result queue; takes up to two results a cycle, gives one when the reader is ready.
// Depends on dcc_hb_pkg and the assertion macro header.
`include "dcc_half_bit_decoder_macros.svh"
module dcc_hb_outq
    import dcc_hb_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    output logic    o_space_ok,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    t_result               r_mem [OQ_DEPTH];
    logic [OQ_PTR_W-1:0]   r_wr_ptr;
    logic [OQ_PTR_W-1:0]   r_rd_ptr;
    logic [OQ_CNT_W-1:0]   r_count;
    logic                  pop;
    logic [OQ_PTR_W-1:0]   wr_ptr_2nd;
    logic [OQ_CNT_W:0]     fill_after;
    logic                  drain_last;

    assign o_valid    = (r_count != '0);
    assign o_result   = r_mem[r_rd_ptr];
    assign pop        = o_valid && i_ready;
    assign o_space_ok = (r_count <= OQ_CNT_W'(OQ_DEPTH - 2));
    assign wr_ptr_2nd = r_wr_ptr + OQ_PTR_W'(1);

    // fill level once this cycle's results are written, and the last pop of a run
    assign fill_after = {1'b0, r_count} + (OQ_CNT_W + 1)'(i_push.n);
    assign drain_last = pop && (r_count == OQ_CNT_W'(1)) && (i_push.n == 2'd0);

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + OQ_PTR_W'(i_push.n);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + OQ_PTR_W'(1);
            end
            r_count <= r_count + OQ_CNT_W'(i_push.n) - OQ_CNT_W'(pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.slot[0];
        end
        if (i_push.n == 2'd2) begin
            r_mem[wr_ptr_2nd] <= i_push.slot[1];
        end
    end

    `DCC_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= OQ_CNT_W'(OQ_DEPTH))
    `DCC_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, i_push.n != 2'd0, fill_after <= 3'(OQ_DEPTH))
    `DCC_ASSERT_NEXT(a_drain_empty, i_clk, i_rst_n, drain_last, !o_valid)

endmodule
